### hw/rtl/cfct_pkg.sv
// shared types and constants for the chat format code translator
// no dependencies; used by every module in hw/rtl
package cfct_pkg;

  localparam int unsigned CharW      = 16;
  localparam int unsigned NumSlots   = 11;
  localparam int unsigned SlotIdxW   = 4;
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QPtrW      = 1;
  localparam int unsigned QCntW      = 2;
  localparam int unsigned AddrW      = 3;

  // register indexes
  localparam logic [0:0] RegStrip  = 1'b0;
  localparam logic [0:0] RegDouble = 1'b1;

  // output slot order of one command
  localparam logic [SlotIdxW-1:0] SlotForePct  = 4'd0;
  localparam logic [SlotIdxW-1:0] SlotForeLet  = 4'd1;
  localparam logic [SlotIdxW-1:0] SlotForeTens = 4'd2;
  localparam logic [SlotIdxW-1:0] SlotForeOnes = 4'd3;
  localparam logic [SlotIdxW-1:0] SlotComma    = 4'd4;
  localparam logic [SlotIdxW-1:0] SlotBackPct  = 4'd5;
  localparam logic [SlotIdxW-1:0] SlotBackLet  = 4'd6;
  localparam logic [SlotIdxW-1:0] SlotBackTens = 4'd7;
  localparam logic [SlotIdxW-1:0] SlotBackOnes = 4'd8;
  localparam logic [SlotIdxW-1:0] SlotMain0    = 4'd9;
  localparam logic [SlotIdxW-1:0] SlotMain1    = 4'd10;

  // control codes and characters
  localparam logic [CharW-1:0] ChNul     = 16'h0000;
  localparam logic [CharW-1:0] ChBold    = 16'h0002;
  localparam logic [CharW-1:0] ChColor   = 16'h0003;
  localparam logic [CharW-1:0] ChReset   = 16'h000F;
  localparam logic [CharW-1:0] ChItalics = 16'h0016;
  localparam logic [CharW-1:0] ChUnder   = 16'h001F;
  localparam logic [CharW-1:0] ChPercent = 16'h0025;
  localparam logic [CharW-1:0] ChComma   = 16'h002C;
  localparam logic [CharW-1:0] ChZero    = 16'h0030;
  localparam logic [CharW-1:0] ChNine    = 16'h0039;

  localparam logic [7:0] LetC = 8'h43;
  localparam logic [7:0] LetF = 8'h46;
  localparam logic [7:0] LetB = 8'h42;
  localparam logic [7:0] LetI = 8'h49;
  localparam logic [7:0] LetU = 8'h55;
  localparam logic [7:0] LetR = 8'h72;
  localparam logic [7:0] LowerBit = 8'h20;

  localparam logic [6:0] ColorDefault = 7'd99;

  typedef enum logic [2:0] {
    PhPlain     = 3'd0,
    PhAfterCode = 3'd1,
    PhFore1     = 3'd2,
    PhFore2     = 3'd3,
    PhComma     = 3'd4,
    PhBack1     = 3'd5
  } phase_e;

  typedef struct packed {
    logic [CharW-1:0] char_code;
    logic             end_of_text;
  } in_item_t;

  typedef struct packed {
    logic [CharW-1:0] out_char;
    logic             last_of_run;
    logic             is_terminator;
  } out_item_t;

  // one classified input item, expanded later by the back end
  typedef struct packed {
    logic [NumSlots-1:0] mask;
    logic                fore_dflt;   // uppercase fore letter, no digits
    logic [3:0]          fore_v;
    logic                back_dflt;
    logic [3:0]          back_v;
    logic [CharW-1:0]    main0;
    logic [CharW-1:0]    main1;
    logic                term;
  } cmd_t;

endpackage

### hw/rtl/cfct_front.sv
// front end: accepts input characters, tracks attribute and color state,
// builds one command per item; depends on cfct_pkg
module cfct_front #(
  parameter int unsigned CHAR_BITS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  cfct_pkg::in_item_t in_data_i,
  input  logic              strip_i,
  input  logic              dbl_i,
  input  logic              full_i,
  output logic              push_o,
  output cfct_pkg::cmd_t    cmd_o
);
  import cfct_pkg::*;

  phase_e     phase_q, phase_d;
  logic       bold_q, bold_d, ital_q, ital_d, und_q, und_d;
  logic [6:0] fore_q, fore_d, back_q, back_d;

  logic [CharW-1:0] c;
  logic             fin, dig, accept, do_main;
  logic [3:0]       d;
  logic             tag_fore, tag_back, cf, comma;
  logic [6:0]       back_tag;
  logic [6:0]       fore_ext, back_ext;
  logic [7:0]       letter;
  logic             main_tag, main_one, main_two;
  cmd_t             cmd;

  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && !full_i;

  always_comb begin
    for (int i = 0; i < CharW; i++) begin
      c[i] = in_data_i.char_code[i] && (i < CHAR_BITS);
    end
  end

  assign fin = in_data_i.end_of_text || (c == ChNul);
  assign dig = !fin && (c >= ChZero) && (c <= ChNine);
  assign d   = c[3:0];

  // value * 10 + digit, values stay below 100
  assign fore_ext = 7'((fore_q << 3) + (fore_q << 1) + {3'd0, d});
  assign back_ext = 7'((back_q << 3) + (back_q << 1) + {3'd0, d});

  always_comb begin
    phase_d  = phase_q;
    bold_d   = bold_q;
    ital_d   = ital_q;
    und_d    = und_q;
    fore_d   = fore_q;
    back_d   = back_q;
    tag_fore = 1'b0;
    tag_back = 1'b0;
    cf       = 1'b0;
    comma    = 1'b0;
    do_main  = 1'b0;
    back_tag = back_q;
    main_tag = 1'b0;
    main_one = 1'b0;
    main_two = 1'b0;
    letter   = LetR;
    cmd      = '0;

    case (phase_q)
      PhAfterCode: begin
        if (dig) begin
          fore_d  = {3'd0, d};
          phase_d = PhFore1;
        end else begin
          cf      = 1'b1;
          phase_d = PhPlain;
          do_main = 1'b1;
        end
      end
      PhFore1, PhFore2: begin
        if (dig && phase_q == PhFore1) begin
          fore_d  = fore_ext;
          phase_d = PhFore2;
        end else if (!fin && c == ChComma) begin
          phase_d = PhComma;
        end else begin
          tag_fore = 1'b1;
          phase_d  = PhPlain;
          do_main  = 1'b1;
        end
      end
      PhComma: begin
        if (dig) begin
          back_d  = {3'd0, d};
          phase_d = PhBack1;
        end else begin
          tag_fore = 1'b1;
          comma    = 1'b1;
          phase_d  = PhPlain;
          do_main  = 1'b1;
        end
      end
      PhBack1: begin
        phase_d  = PhPlain;
        tag_fore = 1'b1;
        tag_back = 1'b1;
        if (dig) begin
          back_d   = back_ext;
          back_tag = back_ext;
        end else begin
          do_main = 1'b1;
        end
      end
      default: begin
        phase_d = PhPlain;
        do_main = 1'b1;
      end
    endcase

    if (do_main) begin
      if (fin) begin
        main_one = 1'b1;
        bold_d   = 1'b0;
        ital_d   = 1'b0;
        und_d    = 1'b0;
        phase_d  = PhPlain;
        fore_d   = '0;
        back_d   = '0;
      end else begin
        case (c)
          ChPercent: begin
            main_one = 1'b1;
            main_two = dbl_i;
          end
          ChBold: begin
            main_tag = 1'b1;
            letter   = bold_q ? LetB : (LetB | LowerBit);
            bold_d   = !bold_q;
          end
          ChReset: begin
            main_tag = 1'b1;
            letter   = LetR;
            bold_d   = 1'b0;
            und_d    = 1'b0;
          end
          ChItalics: begin
            main_tag = 1'b1;
            letter   = ital_q ? LetI : (LetI | LowerBit);
            ital_d   = !ital_q;
          end
          ChUnder: begin
            main_tag = 1'b1;
            letter   = und_q ? LetU : (LetU | LowerBit);
            und_d    = !und_q;
          end
          ChColor: begin
            phase_d = PhAfterCode;
            fore_d  = '0;
            back_d  = '0;
          end
          default: begin
            main_one = 1'b1;
          end
        endcase
      end
    end

    cmd.fore_dflt = cf || (fore_q == ColorDefault);
    cmd.fore_v    = fore_q[3:0];
    cmd.back_dflt = cf || (back_tag == ColorDefault);
    cmd.back_v    = back_tag[3:0];
    cmd.term      = fin;
    cmd.main0     = main_tag ? ChPercent : (fin ? ChNul : c);
    cmd.main1     = main_tag ? {8'd0, letter} : ChPercent;

    cmd.mask[SlotForePct]  = !strip_i && (cf || tag_fore);
    cmd.mask[SlotForeLet]  = !strip_i && (cf || tag_fore);
    cmd.mask[SlotForeTens] = !strip_i && tag_fore && (fore_q != ColorDefault);
    cmd.mask[SlotForeOnes] = !strip_i && tag_fore && (fore_q != ColorDefault);
    cmd.mask[SlotComma]    = comma;
    cmd.mask[SlotBackPct]  = !strip_i && (cf || tag_back);
    cmd.mask[SlotBackLet]  = !strip_i && (cf || tag_back);
    cmd.mask[SlotBackTens] = !strip_i && tag_back && (back_tag != ColorDefault);
    cmd.mask[SlotBackOnes] = !strip_i && tag_back && (back_tag != ColorDefault);
    cmd.mask[SlotMain0]    = main_one || (main_tag && !strip_i);
    cmd.mask[SlotMain1]    = main_two || (main_tag && !strip_i);
  end

  assign cmd_o  = cmd;
  assign push_o = accept && (cmd.mask != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhPlain;
      bold_q  <= 1'b0;
      ital_q  <= 1'b0;
      und_q   <= 1'b0;
      fore_q  <= '0;
      back_q  <= '0;
    end else if (accept) begin
      phase_q <= phase_d;
      bold_q  <= bold_d;
      ital_q  <= ital_d;
      und_q   <= und_d;
      fore_q  <= fore_d;
      back_q  <= back_d;
    end
  end

endmodule

### hw/rtl/cfct_queue.sv
// short command queue between front and back end
// depends on cfct_pkg
module cfct_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  cfct_pkg::cmd_t cmd_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output cfct_pkg::cmd_t head_o
);
  import cfct_pkg::*;

  cmd_t             mem_q [QueueDepth];
  logic [QPtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [QCntW-1:0] cnt_q, cnt_d;
  logic             do_pop;

  assign full_o  = (cnt_q == QCntW'(QueueDepth));
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rd_q];
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_d  = push_i ? QPtrW'(wr_q + 1'b1) : wr_q;
    rd_d  = do_pop ? QPtrW'(rd_q + 1'b1) : rd_q;
    cnt_d = cnt_q;
    if (push_i && !do_pop) begin
      cnt_d = QCntW'(cnt_q + 1'b1);
    end else if (do_pop && !push_i) begin
      cnt_d = QCntW'(cnt_q - 1'b1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

### hw/rtl/cfct_back.sv
// back end: expands one command into output characters, one per cycle
// while the receiver is ready, into an output register; depends on cfct_pkg
module cfct_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                q_valid_i,
  input  cfct_pkg::cmd_t      q_head_i,
  output logic                q_pop_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output cfct_pkg::out_item_t out_data_o
);
  import cfct_pkg::*;

  cmd_t                cur_q;
  logic                cur_valid_q;
  logic [NumSlots-1:0] rem_q, rem_left;
  logic                out_valid_q;
  out_item_t           out_q, out_d;
  logic [SlotIdxW-1:0] idx;
  logic                emit, last, load;
  logic [3:0]          ones;
  logic                tens;
  logic [3:0]          dv;

  // lowest pending slot goes out first
  always_comb begin
    idx = SlotMain1;
    for (int i = NumSlots - 1; i >= 0; i--) begin
      if (rem_q[i]) begin
        idx = SlotIdxW'(i);
      end
    end
  end

  always_comb begin
    rem_left      = rem_q;
    rem_left[idx] = 1'b0;
  end

  assign emit    = cur_valid_q && (!out_valid_q || out_ready_i);
  assign last    = (rem_left == '0);
  assign load    = !cur_valid_q || (emit && last);
  assign q_pop_o = load && q_valid_i;

  assign dv   = (idx == SlotBackTens || idx == SlotBackOnes) ? cur_q.back_v : cur_q.fore_v;
  assign tens = (dv >= 4'd10);
  assign ones = tens ? 4'(dv - 4'd10) : dv;

  always_comb begin
    out_d               = '0;
    out_d.last_of_run   = last;
    out_d.is_terminator = (idx == SlotMain0) && cur_q.term;
    case (idx)
      SlotForePct, SlotBackPct: out_d.out_char = ChPercent;
      SlotForeLet: out_d.out_char = {8'd0, cur_q.fore_dflt ? LetC : (LetC | LowerBit)};
      SlotBackLet: out_d.out_char = {8'd0, cur_q.back_dflt ? LetF : (LetF | LowerBit)};
      SlotForeTens, SlotBackTens: out_d.out_char = ChZero | {15'd0, tens};
      SlotForeOnes, SlotBackOnes: out_d.out_char = ChZero | {12'd0, ones};
      SlotComma:   out_d.out_char = ChComma;
      SlotMain0:   out_d.out_char = cur_q.main0;
      SlotMain1:   out_d.out_char = cur_q.main1;
      default:     out_d.out_char = ChNul;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_q <= out_d;
    end
    if (q_pop_o) begin
      cur_q <= q_head_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
      rem_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (load) begin
        cur_valid_q <= q_valid_i;
        rem_q       <= q_head_i.mask;
      end else if (emit) begin
        rem_q <= rem_left;
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

### hw/rtl/chat_format_code_translator_unit.sv
// chat format code translator, top level
// usage:
//   input channel (in_valid_i/in_ready_o/in_data_i) takes one text character
//   per request; end_of_text or a zero character ends the string.
//   output channel (out_valid_o/out_ready_i/out_data_o) gives the rewritten
//   characters, up to ten per input request, last_of_run on the final one and
//   is_terminator on the zero that closes the string.
//   apb port: register 0 strip_mode at 0x0, register 1 double_percent at 0x4.
//   write only while the block is idle.
// timing:
//   the front end takes one request per cycle while its two-entry command
//   queue has room; the back end emits one character per cycle while the
//   receiver is ready (one character per request for plain text).
//   output is registered: queue entry, current command, output register.
//   requests that only extend a color code produce nothing.
// reset clears attribute and color state, empties the queue and restores
// strip_mode 0 and double_percent 1. when the receiver stalls, the output
// register holds and the queue fills, then in_ready_o drops.
// depends on cfct_pkg, cfct_front, cfct_queue, cfct_back
module chat_format_code_translator_unit #(
  parameter int unsigned CHAR_BITS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  cfct_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output cfct_pkg::out_item_t out_data_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [cfct_pkg::AddrW-1:0] paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import cfct_pkg::*;

  logic strip_q, dbl_q;
  logic wr_en;
  logic full, push, q_valid, q_pop;
  cmd_t push_cmd, head;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strip_q <= 1'b0;
      dbl_q   <= 1'b1;
    end else if (wr_en) begin
      case (paddr[2])
        RegStrip:  strip_q <= pwdata[0];
        RegDouble: dbl_q   <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      RegStrip:  prdata = {31'd0, strip_q};
      RegDouble: prdata = {31'd0, dbl_q};
      default:   prdata = '0;
    endcase
  end

  cfct_front #(
    .CHAR_BITS(CHAR_BITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .strip_i    (strip_q),
    .dbl_i      (dbl_q),
    .full_i     (full),
    .push_o     (push),
    .cmd_o      (push_cmd)
  );

  cfct_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .full_o  (full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .head_o  (head)
  );

  cfct_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_head_i    (head),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule
